/* design/vrsvt_pkg.sv */
// ----------------------------------------------------------------------------
// vrsvt_pkg
// Shared widths, types, rounding helpers and the constant trig / scale tables
// of the vertex rotate, scale and view transform.
// ----------------------------------------------------------------------------
package vrsvt_pkg;

   localparam int WORD_W        = 24;
   localparam int FRAC_BITS     = 16;
   localparam int ROT_DIVISIONS = 36;
   localparam int SCALE_LIMIT   = 16;

   localparam int ROT_W     = 8;
   localparam int SSTEP_W   = 6;
   localparam int CLAMP_W   = SSTEP_W + 1;
   localparam int CSR_IDX_W = 2;

   localparam int ROT_IDX_W     = $clog2(ROT_DIVISIONS);
   localparam int TRIG_W        = FRAC_BITS + 2;
   localparam int SCALE_ENTRIES = 2 * SCALE_LIMIT + 1;
   localparam int SIDX_W        = $clog2(SCALE_ENTRIES);
   // 1.25^k < 2^(k/3): integer bits plus sign
   localparam int SCALE_W       = FRAC_BITS + SCALE_LIMIT / 3 + 2;
   localparam int DIFF_W        = WORD_W + 1;
   localparam int ROT_PROD_W    = DIFF_W + TRIG_W;
   localparam int SCL_PROD_W    = DIFF_W + SCALE_W;
   localparam int VIEW_PROD_W   = 2 * WORD_W;

   localparam longint unsigned HALF_PI_Q31 = 64'd3373259426;

   localparam logic [CSR_IDX_W-1:0] CSR_VIEW_SCALE_X  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_VIEW_SCALE_Y  = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_VIEW_OFFSET_X = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_VIEW_OFFSET_Y = CSR_IDX_W'(3);

   typedef logic signed [WORD_W-1:0]   word_type;
   typedef logic signed [DIFF_W-1:0]   diff_type;
   typedef logic signed [TRIG_W-1:0]   trig_type;
   typedef logic signed [SCALE_W-1:0]  scale_type;
   typedef logic [ROT_IDX_W-1:0]       rot_idx_type;
   typedef logic [SIDX_W-1:0]          scale_idx_type;
   typedef logic signed [ROT_PROD_W-1:0]  rot_prod_type;
   typedef logic signed [SCL_PROD_W-1:0]  scl_prod_type;
   typedef logic signed [VIEW_PROD_W-1:0] view_prod_type;

   typedef trig_type    trig_tab_type  [ROT_DIVISIONS];
   typedef scale_type   scale_tab_type [SCALE_ENTRIES];
   typedef rot_idx_type rot_map_type   [2**ROT_W];

   // fields that ride along the pipeline untouched by the rotate stages
   typedef struct packed {
      word_type      z;
      word_type      w;
      word_type      pvx;
      word_type      pvy;
      logic          scale_en;
      scale_idx_type scale_idx;
   } side_type;

   localparam word_type VIEW_SCALE_RST  = word_type'(64'd1 << FRAC_BITS);
   localparam word_type VIEW_OFFSET_RST = word_type'(0);

   localparam logic signed [63:0] WORD_MAX = (64'sd1 <<< (WORD_W - 1)) - 64'sd1;
   localparam logic signed [63:0] WORD_MIN = -(64'sd1 <<< (WORD_W - 1));

   function automatic word_type sat_word(input logic signed [63:0] v);
      word_type r;
      if (v > WORD_MAX) begin
         r = WORD_MAX[WORD_W-1:0];
      end else if (v < WORD_MIN) begin
         r = WORD_MIN[WORD_W-1:0];
      end else begin
         r = v[WORD_W-1:0];
      end
      return r;
   endfunction

   // round half up back to FRAC_BITS
   function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v);
      return (v + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
   endfunction

   // Q31 Taylor series on 0..pi/4, result in Q(FRAC_BITS)
   function automatic longint trig_base(input longint unsigned a, input logic want_cos);
      longint unsigned a2;
      longint unsigned ts;
      longint unsigned tc;
      longint          acc_s;
      longint          acc_c;
      a2    = (a * a) >> 31;
      ts    = a;
      tc    = 64'd1 << 31;
      acc_s = longint'(a);
      acc_c = longint'(tc);
      for (int n = 1; n <= 6; n++) begin
         case (n)
            1: begin
               ts = ((ts * a2) >> 31) / 6;
               tc = ((tc * a2) >> 31) / 2;
            end
            2: begin
               ts = ((ts * a2) >> 31) / 20;
               tc = ((tc * a2) >> 31) / 12;
            end
            3: begin
               ts = ((ts * a2) >> 31) / 42;
               tc = ((tc * a2) >> 31) / 30;
            end
            4: begin
               ts = ((ts * a2) >> 31) / 72;
               tc = ((tc * a2) >> 31) / 56;
            end
            5: begin
               ts = ((ts * a2) >> 31) / 110;
               tc = ((tc * a2) >> 31) / 90;
            end
            default: begin
               ts = ((ts * a2) >> 31) / 156;
               tc = ((tc * a2) >> 31) / 132;
            end
         endcase
         if (n[0]) begin
            acc_s = acc_s - longint'(ts);
            acc_c = acc_c - longint'(tc);
         end else begin
            acc_s = acc_s + longint'(ts);
            acc_c = acc_c + longint'(tc);
         end
      end
      if (want_cos) begin
         return (acc_c + (64'sd1 <<< (30 - FRAC_BITS))) >>> (31 - FRAC_BITS);
      end
      return (acc_s + (64'sd1 <<< (30 - FRAC_BITS))) >>> (31 - FRAC_BITS);
   endfunction

   function automatic trig_tab_type build_trig(input logic want_cos);
      trig_tab_type    t;
      longint unsigned u;
      longint unsigned q;
      longint unsigned r;
      longint unsigned a;
      longint          s;
      longint          c;
      longint          tmp;
      longint          fs;
      longint          fc;
      logic            swap;
      for (int i = 0; i < ROT_DIVISIONS; i++) begin
         u    = 64'(4 * i);
         q    = u / ROT_DIVISIONS;
         r    = u % ROT_DIVISIONS;
         swap = (2 * r > ROT_DIVISIONS);
         if (swap) begin
            a = (HALF_PI_Q31 * (ROT_DIVISIONS - r) + ROT_DIVISIONS / 2) / ROT_DIVISIONS;
         end else begin
            a = (HALF_PI_Q31 * r + ROT_DIVISIONS / 2) / ROT_DIVISIONS;
         end
         s = trig_base(a, 1'b0);
         c = trig_base(a, 1'b1);
         if (swap) begin
            tmp = s;
            s   = c;
            c   = tmp;
         end
         case (q[1:0])
            2'd0: begin
               fs = s;
               fc = c;
            end
            2'd1: begin
               fs = c;
               fc = -s;
            end
            2'd2: begin
               fs = -s;
               fc = -c;
            end
            default: begin
               fs = -c;
               fc = s;
            end
         endcase
         t[i] = want_cos ? trig_type'(fc) : trig_type'(fs);
      end
      return t;
   endfunction

   // round(1.25^k * 2^FRAC_BITS), ties up, by exact long division
   function automatic scale_tab_type build_scale();
      scale_tab_type t;
      logic [127:0]  p;
      logic [127:0]  q;
      logic [127:0]  r;
      logic [63:0]   quo;
      int            k;
      int            m;
      for (int idx = 0; idx < SCALE_ENTRIES; idx++) begin
         k = idx - SCALE_LIMIT;
         m = (k < 0) ? -k : k;
         p = 128'd1;
         q = 128'd1;
         for (int j = 0; j < m; j++) begin
            if (k > 0) begin
               p = p * 128'd5;
               q = q * 128'd4;
            end else begin
               p = p * 128'd4;
               q = q * 128'd5;
            end
         end
         p   = p << FRAC_BITS;
         r   = 128'd0;
         quo = 64'd0;
         for (int b = 127; b >= 0; b--) begin
            r = {r[126:0], p[b]};
            if (r >= q) begin
               r   = r - q;
               quo = {quo[62:0], 1'b1};
            end else begin
               quo = {quo[62:0], 1'b0};
            end
         end
         if ((r << 1) >= q) begin
            quo = quo + 64'd1;
         end
         t[idx] = quo[SCALE_W-1:0];
      end
      return t;
   endfunction

   // raw signed step count to index mod ROT_DIVISIONS
   function automatic rot_map_type build_rot_map();
      rot_map_type t;
      int          v;
      int          r;
      for (int j = 0; j < 2**ROT_W; j++) begin
         v = (j < 2**(ROT_W - 1)) ? j : j - 2**ROT_W;
         r = v % ROT_DIVISIONS;
         if (r < 0) begin
            r = r + ROT_DIVISIONS;
         end
         t[j] = rot_idx_type'(r);
      end
      return t;
   endfunction

   localparam trig_tab_type  SIN_TAB   = build_trig(1'b0);
   localparam trig_tab_type  COS_TAB   = build_trig(1'b1);
   localparam scale_tab_type SCALE_TAB = build_scale();
   localparam rot_map_type   ROT_MAP   = build_rot_map();

endpackage

/* design/vrsvt_rotate.sv */
// ----------------------------------------------------------------------------
// vrsvt_rotate
// Three-stage rotation about the pivot: table read and pivot difference,
// four products, then round, re-add pivot and saturate; bypassed without in_rot_en.
// ----------------------------------------------------------------------------
module vrsvt_rotate (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  vrsvt_pkg::word_type    in_x,
   input  vrsvt_pkg::word_type    in_y,
   input  logic                  in_rot_en,
   input  vrsvt_pkg::rot_idx_type in_rot_idx,
   input  vrsvt_pkg::side_type    in_side,
   output logic                  out_valid,
   output vrsvt_pkg::word_type    out_x,
   output vrsvt_pkg::word_type    out_y,
   output vrsvt_pkg::side_type    out_side
);
   import vrsvt_pkg::*;

   // stage a: differences and table entries
   logic         va_ff;
   diff_type     dxa_ff, dxa_in;
   diff_type     dya_ff, dya_in;
   trig_type     sina_ff, cosa_ff;
   word_type     xa_ff, ya_ff;
   logic         ena_ff;
   side_type     sidea_ff;

   // stage b: products
   logic         vb_ff;
   rot_prod_type pcx_ff, pcx_in;
   rot_prod_type psy_ff, psy_in;
   rot_prod_type pcy_ff, pcy_in;
   rot_prod_type psx_ff, psx_in;
   word_type     xb_ff, yb_ff;
   logic         enb_ff;
   side_type     sideb_ff;

   // stage c: result
   logic         vc_ff;
   word_type     xc_ff, xc_in;
   word_type     yc_ff, yc_in;
   side_type     sidec_ff;

   assign dxa_in = diff_type'(in_x) - diff_type'(in_side.pvx);
   assign dya_in = diff_type'(in_y) - diff_type'(in_side.pvy);

   assign pcx_in = dxa_ff * cosa_ff;
   assign psy_in = dya_ff * sina_ff;
   assign pcy_in = dya_ff * cosa_ff;
   assign psx_in = dxa_ff * sina_ff;

   // clockwise: x' = dx*cos + dy*sin, y' = dy*cos - dx*sin
   always_comb begin
      if (enb_ff) begin
         xc_in = sat_word(rnd_shift(64'(pcx_ff) + 64'(psy_ff)) + 64'(sideb_ff.pvx));
         yc_in = sat_word(rnd_shift(64'(pcy_ff) - 64'(psx_ff)) + 64'(sideb_ff.pvy));
      end else begin
         xc_in = xb_ff;
         yc_in = yb_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
      end else begin
         va_ff <= in_valid;
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
      end
   end

   always_ff @(posedge clock) begin
      dxa_ff   <= dxa_in;
      dya_ff   <= dya_in;
      sina_ff  <= SIN_TAB[in_rot_idx];
      cosa_ff  <= COS_TAB[in_rot_idx];
      xa_ff    <= in_x;
      ya_ff    <= in_y;
      ena_ff   <= in_rot_en;
      sidea_ff <= in_side;

      pcx_ff   <= pcx_in;
      psy_ff   <= psy_in;
      pcy_ff   <= pcy_in;
      psx_ff   <= psx_in;
      xb_ff    <= xa_ff;
      yb_ff    <= ya_ff;
      enb_ff   <= ena_ff;
      sideb_ff <= sidea_ff;

      xc_ff    <= xc_in;
      yc_ff    <= yc_in;
      sidec_ff <= sideb_ff;
   end

   assign out_valid = vc_ff;
   assign out_x     = xc_ff;
   assign out_y     = yc_ff;
   assign out_side  = sidec_ff;

endmodule

/* design/vertex_rotate_scale_view_transform.sv */
// ----------------------------------------------------------------------------
// vertex_rotate_scale_view_transform
// Per-vertex translate, rotate and scale about a pivot, then view scale and
// offset on x and y; z and w pass through.
// ----------------------------------------------------------------------------
//  channel   ports                    handshake
//  request   req_*                    beat taken when start && !busy
//  response  rsp_*                    rsp_valid strobe, one cycle per beat
//  config    csr_write/index/data     written on any edge with csr_write outside reset
//
//  One beat per cycle, through the nine-stage pipeline (translate, three
//  rotate stages, three scale stages, view multiply, view sum) to rsp_*.
//  busy stays low: the pipeline never stalls and the receiver cannot either.
//  Synchronous reset clears the stage valid bits and restores the view
//  registers; the sine, cosine and scale tables are constants.
// ----------------------------------------------------------------------------
module vertex_rotate_scale_view_transform (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  vrsvt_pkg::word_type                   req_pos_x,
   input  vrsvt_pkg::word_type                   req_pos_y,
   input  vrsvt_pkg::word_type                   req_pos_z,
   input  vrsvt_pkg::word_type                   req_pos_w,
   input  vrsvt_pkg::word_type                   req_offset_x,
   input  vrsvt_pkg::word_type                   req_offset_y,
   input  vrsvt_pkg::word_type                   req_pivot_x,
   input  vrsvt_pkg::word_type                   req_pivot_y,
   input  logic signed [vrsvt_pkg::ROT_W-1:0]     req_rot_steps,
   input  logic signed [vrsvt_pkg::SSTEP_W-1:0]   req_scale_steps,
   output logic                                 rsp_valid,
   output vrsvt_pkg::word_type                   rsp_out_x,
   output vrsvt_pkg::word_type                   rsp_out_y,
   output vrsvt_pkg::word_type                   rsp_out_z,
   output vrsvt_pkg::word_type                   rsp_out_w,
   input  logic                                 csr_write,
   input  logic [vrsvt_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [vrsvt_pkg::WORD_W-1:0]           csr_data
);
   import vrsvt_pkg::*;

   // view registers
   word_type view_scale_x_ff, view_scale_y_ff;
   word_type view_offset_x_ff, view_offset_y_ff;

   logic accept;

   // stage 1: translate, step decode
   logic                       v1_ff;
   word_type                   x1_ff, x1_in;
   word_type                   y1_ff, y1_in;
   logic                       rot_en1_ff;
   rot_idx_type                rot_idx1_ff;
   side_type                   side1_ff, side1_in;
   logic signed [CLAMP_W-1:0]  ss_ext;
   logic signed [CLAMP_W-1:0]  ss_clamp;
   logic [CLAMP_W-1:0]         ss_idx;

   // rotate output (stage 4)
   logic     v4;
   word_type x4, y4;
   side_type side4;

   // stage 5: scale differences and factor
   logic      v5_ff;
   diff_type  dx5_ff, dx5_in;
   diff_type  dy5_ff, dy5_in;
   scale_type m5_ff;
   word_type  x5_ff, y5_ff;
   side_type  side5_ff;

   // stage 6: scale products
   logic         v6_ff;
   scl_prod_type px6_ff, px6_in;
   scl_prod_type py6_ff, py6_in;
   word_type     x6_ff, y6_ff;
   side_type     side6_ff;

   // stage 7: scaled point
   logic     v7_ff;
   word_type x7_ff, x7_in;
   word_type y7_ff, y7_in;
   side_type side7_ff;

   // stage 8: view products
   logic          v8_ff;
   view_prod_type vx8_ff, vx8_in;
   view_prod_type ox8_ff, ox8_in;
   view_prod_type vy8_ff, vy8_in;
   view_prod_type oy8_ff, oy8_in;
   side_type      side8_ff;

   // stage 9: output registers
   logic     v9_ff;
   word_type out_x9_ff, out_x9_in;
   word_type out_y9_ff, out_y9_in;
   word_type out_z9_ff, out_w9_ff;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         view_scale_x_ff  <= VIEW_SCALE_RST;
         view_scale_y_ff  <= VIEW_SCALE_RST;
         view_offset_x_ff <= VIEW_OFFSET_RST;
         view_offset_y_ff <= VIEW_OFFSET_RST;
      end else if (csr_write) begin
         case (csr_index)
            CSR_VIEW_SCALE_X:  view_scale_x_ff  <= csr_data;
            CSR_VIEW_SCALE_Y:  view_scale_y_ff  <= csr_data;
            CSR_VIEW_OFFSET_X: view_offset_x_ff <= csr_data;
            CSR_VIEW_OFFSET_Y: view_offset_y_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // ---- stage 1 ----
   always_comb begin
      ss_ext = CLAMP_W'(req_scale_steps);
      if (ss_ext > CLAMP_W'(SCALE_LIMIT)) begin
         ss_clamp = CLAMP_W'(SCALE_LIMIT);
      end else if (ss_ext < -CLAMP_W'(SCALE_LIMIT)) begin
         ss_clamp = -CLAMP_W'(SCALE_LIMIT);
      end else begin
         ss_clamp = ss_ext;
      end
      ss_idx = ss_clamp + CLAMP_W'(SCALE_LIMIT);

      x1_in = sat_word(64'(req_pos_x) + 64'(req_offset_x));
      y1_in = sat_word(64'(req_pos_y) + 64'(req_offset_y));

      side1_in.z         = req_pos_z;
      side1_in.w         = req_pos_w;
      side1_in.pvx       = req_pivot_x;
      side1_in.pvy       = req_pivot_y;
      // scale code of one means no scaling
      side1_in.scale_en  = (req_scale_steps != SSTEP_W'(1));
      side1_in.scale_idx = ss_idx[SIDX_W-1:0];
   end

   always_ff @(posedge clock) begin
      x1_ff       <= x1_in;
      y1_ff       <= y1_in;
      rot_en1_ff  <= (req_rot_steps != ROT_W'(0));
      rot_idx1_ff <= ROT_MAP[$unsigned(req_rot_steps)];
      side1_ff    <= side1_in;
   end

   // ---- stages 2 to 4 ----
   vrsvt_rotate u_rotate (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (v1_ff),
      .in_x       (x1_ff),
      .in_y       (y1_ff),
      .in_rot_en  (rot_en1_ff),
      .in_rot_idx (rot_idx1_ff),
      .in_side    (side1_ff),
      .out_valid  (v4),
      .out_x      (x4),
      .out_y      (y4),
      .out_side   (side4)
   );

   // ---- stages 5 to 7: scale about pivot ----
   assign dx5_in = diff_type'(x4) - diff_type'(side4.pvx);
   assign dy5_in = diff_type'(y4) - diff_type'(side4.pvy);

   assign px6_in = dx5_ff * m5_ff;
   assign py6_in = dy5_ff * m5_ff;

   always_comb begin
      if (side6_ff.scale_en) begin
         x7_in = sat_word(rnd_shift(64'(px6_ff)) + 64'(side6_ff.pvx));
         y7_in = sat_word(rnd_shift(64'(py6_ff)) + 64'(side6_ff.pvy));
      end else begin
         x7_in = x6_ff;
         y7_in = y6_ff;
      end
   end

   // ---- stages 8 and 9: view ----
   assign vx8_in = view_scale_x_ff * x7_ff;
   assign ox8_in = view_offset_x_ff * side7_ff.w;
   assign vy8_in = view_scale_y_ff * y7_ff;
   assign oy8_in = view_offset_y_ff * side7_ff.w;

   assign out_x9_in = sat_word(rnd_shift(64'(vx8_ff) + 64'(ox8_ff)));
   assign out_y9_in = sat_word(rnd_shift(64'(vy8_ff) + 64'(oy8_ff)));

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
         v8_ff <= 1'b0;
         v9_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
         v5_ff <= v4;
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
         v8_ff <= v7_ff;
         v9_ff <= v8_ff;
      end
   end

   always_ff @(posedge clock) begin
      dx5_ff    <= dx5_in;
      dy5_ff    <= dy5_in;
      m5_ff     <= SCALE_TAB[side4.scale_idx];
      x5_ff     <= x4;
      y5_ff     <= y4;
      side5_ff  <= side4;

      px6_ff    <= px6_in;
      py6_ff    <= py6_in;
      x6_ff     <= x5_ff;
      y6_ff     <= y5_ff;
      side6_ff  <= side5_ff;

      x7_ff     <= x7_in;
      y7_ff     <= y7_in;
      side7_ff  <= side6_ff;

      vx8_ff    <= vx8_in;
      ox8_ff    <= ox8_in;
      vy8_ff    <= vy8_in;
      oy8_ff    <= oy8_in;
      side8_ff  <= side7_ff;

      out_x9_ff <= out_x9_in;
      out_y9_ff <= out_y9_in;
      out_z9_ff <= side8_ff.z;
      out_w9_ff <= side8_ff.w;
   end

   assign rsp_valid = v9_ff;
   assign rsp_out_x = out_x9_ff;
   assign rsp_out_y = out_y9_ff;
   assign rsp_out_z = out_z9_ff;
   assign rsp_out_w = out_w9_ff;

`ifndef SYNTHESIS
   a_rsp_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 9))
      else $error("response beat without a request beat nine cycles earlier");

   a_z_through: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_out_z == $past(req_pos_z, 9))
      else $error("z lost its alignment with the beat");

   a_w_through: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_out_w == $past(req_pos_w, 9))
      else $error("w lost its alignment with the beat");
`endif

endmodule

/* bench/tb_vertex_rotate_scale_view_transform.sv */
// ----------------------------------------------------------------------------
// tb_vertex_rotate_scale_view_transform
// Self-checking bench: drives vertex beats with random gaps and predicts
// each transformed vertex with a local fixed-point model (own sine, cosine
// and scale tables). Covers rotate / scale corner codes, saturation at every
// stage and several view register settings, extremes included.
// ----------------------------------------------------------------------------
module tb_vertex_rotate_scale_view_transform;
   import vrsvt_pkg::*;

   localparam int      FRAC        = 16;
   localparam int      ROT_DIV     = 36;
   localparam int      SCALE_LIM   = 16;
   localparam longint  HALF_PI_Q31 = 64'd3373259426;
   localparam longint  ONE_Q16     = 65536;
   localparam longint  WORD_HI     = 8388607;
   localparam longint  WORD_LO     = -8388608;
   localparam int      LATENCY     = 9;
   localparam int      PHASES      = 6;
   localparam int      PHASE_ITEMS = 125;
   localparam int      CYCLE_LIMIT = 200000;
   localparam int      MAX_PRINTS  = 20;

   typedef struct {
      word_type                   pos_x;
      word_type                   pos_y;
      word_type                   pos_z;
      word_type                   pos_w;
      word_type                   offset_x;
      word_type                   offset_y;
      word_type                   pivot_x;
      word_type                   pivot_y;
      logic signed [ROT_W-1:0]    rot_steps;
      logic signed [SSTEP_W-1:0]  scale_steps;
   } vertex_type;

   typedef struct {
      word_type x;
      word_type y;
      word_type z;
      word_type w;
   } xform_type;

   // predicts transformed vertices and checks them in order
   class xform_tracker;
      longint    sin_tab[ROT_DIV];
      longint    cos_tab[ROT_DIV];
      longint    scale_tab[2*SCALE_LIM+1];
      word_type  view_scale_x;
      word_type  view_scale_y;
      word_type  view_offset_x;
      word_type  view_offset_y;
      xform_type expected_xforms[$];
      int        errors;
      int        results;
      int        vertices;

      function new();
         longint unsigned u, q, r, a, a2, ts, tc, p, d, quo;
         longint          sin_acc, cos_acc, s, c, t;
         bit              swap;
         int              k, m;
         view_scale_x  = word_type'(ONE_Q16);
         view_scale_y  = word_type'(ONE_Q16);
         view_offset_x = '0;
         view_offset_y = '0;
         errors   = 0;
         results  = 0;
         vertices = 0;
         for (int i = 0; i < ROT_DIV; i++) begin
            u    = 4 * i;
            q    = u / ROT_DIV;
            r    = u % ROT_DIV;
            swap = (2 * r > ROT_DIV);
            // fold the angle into the first octant
            a = swap ? (HALF_PI_Q31 * (ROT_DIV - r) + ROT_DIV / 2) / ROT_DIV
                     : (HALF_PI_Q31 * r + ROT_DIV / 2) / ROT_DIV;
            a2      = (a * a) >> 31;
            ts      = a;
            tc      = 64'd1 << 31;
            sin_acc = longint'(ts);
            cos_acc = longint'(tc);
            for (int n = 1; n <= 6; n++) begin
               ts = ((ts * a2) >> 31) / ((2 * n) * (2 * n + 1));
               tc = ((tc * a2) >> 31) / ((2 * n - 1) * (2 * n));
               if (n % 2 == 1) begin
                  sin_acc -= longint'(ts);
                  cos_acc -= longint'(tc);
               end else begin
                  sin_acc += longint'(ts);
                  cos_acc += longint'(tc);
               end
            end
            s = (sin_acc + (64'sd1 <<< (30 - FRAC))) >>> (31 - FRAC);
            c = (cos_acc + (64'sd1 <<< (30 - FRAC))) >>> (31 - FRAC);
            if (swap) begin
               t = s;
               s = c;
               c = t;
            end
            case (q % 4)
               0: begin
                  sin_tab[i] = s;
                  cos_tab[i] = c;
               end
               1: begin
                  sin_tab[i] = c;
                  cos_tab[i] = -s;
               end
               2: begin
                  sin_tab[i] = -s;
                  cos_tab[i] = -c;
               end
               default: begin
                  sin_tab[i] = -c;
                  cos_tab[i] = s;
               end
            endcase
         end
         // 1.25^k in Q16, ties up; fits easily in 64 bits for |k| <= 16
         for (int idx = 0; idx <= 2 * SCALE_LIM; idx++) begin
            k = idx - SCALE_LIM;
            m = (k < 0) ? -k : k;
            p = 1;
            d = 1;
            for (int j = 0; j < m; j++) begin
               if (k > 0) begin
                  p = p * 5;
                  d = d * 4;
               end else begin
                  p = p * 4;
                  d = d * 5;
               end
            end
            p   = p << FRAC;
            quo = p / d;
            if (2 * (p % d) >= d) quo++;
            scale_tab[idx] = longint'(quo);
         end
      endfunction

      function longint sat24(longint v);
         if (v > WORD_HI) return WORD_HI;
         if (v < WORD_LO) return WORD_LO;
         return v;
      endfunction

      function longint round_q(longint v);
         return (v + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, word_type val);
         case (idx)
            CSR_VIEW_SCALE_X:  view_scale_x  = val;
            CSR_VIEW_SCALE_Y:  view_scale_y  = val;
            CSR_VIEW_OFFSET_X: view_offset_x = val;
            default:           view_offset_y = val;
         endcase
      endfunction

      function void note_vertex(vertex_type v);
         longint    x, y, w, cx, cy, dx, dy, nx, ny, mul;
         int        rs, ss, ri;
         xform_type e;
         x  = v.pos_x;
         y  = v.pos_y;
         w  = v.pos_w;
         cx = v.pivot_x;
         cy = v.pivot_y;
         rs = v.rot_steps;
         ss = v.scale_steps;
         x  = sat24(x + longint'(v.offset_x));
         y  = sat24(y + longint'(v.offset_y));
         if (rs != 0) begin
            ri = rs % ROT_DIV;
            if (ri < 0) ri += ROT_DIV;
            dx = x - cx;
            dy = y - cy;
            nx = round_q(dx * cos_tab[ri] + dy * sin_tab[ri]) + cx;
            ny = round_q(dy * cos_tab[ri] - dx * sin_tab[ri]) + cy;
            x  = sat24(nx);
            y  = sat24(ny);
         end
         // scale code 1 bypasses scaling; anything else is clamped first
         if (ss != 1) begin
            if (ss > SCALE_LIM) ss = SCALE_LIM;
            if (ss < -SCALE_LIM) ss = -SCALE_LIM;
            mul = scale_tab[ss + SCALE_LIM];
            dx  = x - cx;
            dy  = y - cy;
            x   = sat24(round_q(dx * mul) + cx);
            y   = sat24(round_q(dy * mul) + cy);
         end
         nx = sat24(round_q(longint'(view_scale_x) * x + longint'(view_offset_x) * w));
         ny = sat24(round_q(longint'(view_scale_y) * y + longint'(view_offset_y) * w));
         e.x = word_type'(nx);
         e.y = word_type'(ny);
         e.z = v.pos_z;
         e.w = v.pos_w;
         expected_xforms.insert(expected_xforms.size(), e);
         vertices++;
      endfunction

      task report(string msg);
         if (errors < MAX_PRINTS) $display("MISMATCH: %s", msg);
         errors++;
      endtask

      task check_xform(word_type x, word_type y, word_type z, word_type w);
         xform_type e;
         results++;
         if (expected_xforms.size() == 0) begin
            report($sformatf("result x=%0d y=%0d with no vertex pending", x, y));
         end else begin
            e = expected_xforms.pop_front();
            if (x !== e.x) report($sformatf("out_x got %0d want %0d", x, e.x));
            if (y !== e.y) report($sformatf("out_y got %0d want %0d", y, e.y));
            if (z !== e.z) report($sformatf("out_z got %0d want %0d", z, e.z));
            if (w !== e.w) report($sformatf("out_w got %0d want %0d", w, e.w));
         end
      endtask

      function int pending();
         return expected_xforms.size();
      endfunction
   endclass

   logic                        clock = 1'b0;
   logic                        reset;
   logic                        start;
   logic                        busy;
   word_type                    req_pos_x, req_pos_y, req_pos_z, req_pos_w;
   word_type                    req_offset_x, req_offset_y;
   word_type                    req_pivot_x, req_pivot_y;
   logic signed [ROT_W-1:0]     req_rot_steps;
   logic signed [SSTEP_W-1:0]   req_scale_steps;
   logic                        rsp_valid;
   word_type                    rsp_out_x, rsp_out_y, rsp_out_z, rsp_out_w;
   logic                        csr_write;
   logic [CSR_IDX_W-1:0]        csr_index;
   logic [WORD_W-1:0]           csr_data;

   xform_tracker tracker;
   int           cycle_count = 0;
   int           reg_writes  = 0;
   bit           quiet       = 1'b0;
   vertex_type   directed_q[$];

   vertex_rotate_scale_view_transform i_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_pos_x       (req_pos_x),
      .req_pos_y       (req_pos_y),
      .req_pos_z       (req_pos_z),
      .req_pos_w       (req_pos_w),
      .req_offset_x    (req_offset_x),
      .req_offset_y    (req_offset_y),
      .req_pivot_x     (req_pivot_x),
      .req_pivot_y     (req_pivot_y),
      .req_rot_steps   (req_rot_steps),
      .req_scale_steps (req_scale_steps),
      .rsp_valid       (rsp_valid),
      .rsp_out_x       (rsp_out_x),
      .rsp_out_y       (rsp_out_y),
      .rsp_out_z       (rsp_out_z),
      .rsp_out_w       (rsp_out_w),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("tb_vertex_rotate_scale_view_transform NOT OK");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) tracker.check_xform(rsp_out_x, rsp_out_y, rsp_out_z, rsp_out_w);
   end

   function automatic vertex_type mk_vertex(longint px, longint py, longint pz, longint pw,
                                            longint ox, longint oy, longint cx, longint cy,
                                            int rs, int ss);
      vertex_type v;
      v.pos_x       = word_type'(px);
      v.pos_y       = word_type'(py);
      v.pos_z       = word_type'(pz);
      v.pos_w       = word_type'(pw);
      v.offset_x    = word_type'(ox);
      v.offset_y    = word_type'(oy);
      v.pivot_x     = word_type'(cx);
      v.pivot_y     = word_type'(cy);
      v.rot_steps   = ROT_W'(rs);
      v.scale_steps = SSTEP_W'(ss);
      return v;
   endfunction

   function automatic void add_directed(vertex_type v);
      directed_q.insert(directed_q.size(), v);
   endfunction

   // mix of full-range, boundary and moderate values so saturation does not dominate
   function automatic word_type rand_word();
      case ($urandom_range(0, 7))
         0, 1: return word_type'($urandom);
         2: begin
            case ($urandom_range(0, 4))
               0: return word_type'(WORD_HI);
               1: return word_type'(WORD_LO);
               2: return word_type'(0);
               3: return word_type'(-1);
               default: return word_type'(1);
            endcase
         end
         default: return word_type'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
      endcase
   endfunction

   function automatic vertex_type rand_vertex();
      vertex_type v;
      v.pos_x    = rand_word();
      v.pos_y    = rand_word();
      v.pos_z    = word_type'($urandom);
      v.pos_w    = ($urandom_range(0, 2) == 0) ? rand_word() : word_type'(ONE_Q16);
      v.offset_x = rand_word();
      v.offset_y = rand_word();
      v.pivot_x  = rand_word();
      v.pivot_y  = rand_word();
      v.rot_steps = ($urandom_range(0, 7) == 0) ? '0 : ROT_W'($urandom);
      case ($urandom_range(0, 7))
         0:       v.scale_steps = SSTEP_W'(1);
         1, 2:    v.scale_steps = SSTEP_W'($urandom);
         default: v.scale_steps = SSTEP_W'(int'($urandom_range(0, 2 * SCALE_LIM)) - SCALE_LIM);
      endcase
      return v;
   endfunction

   task automatic idle_gap();
      if (!quiet) begin
         while ($urandom_range(0, 99) < 17) begin
            start <= 1'b0;
            @(posedge clock);
         end
      end
   endtask

   // returns at the edge that takes the beat
   task automatic send_vertex(vertex_type v);
      req_pos_x       <= v.pos_x;
      req_pos_y       <= v.pos_y;
      req_pos_z       <= v.pos_z;
      req_pos_w       <= v.pos_w;
      req_offset_x    <= v.offset_x;
      req_offset_y    <= v.offset_y;
      req_pivot_x     <= v.pivot_x;
      req_pivot_y     <= v.pivot_y;
      req_rot_steps   <= v.rot_steps;
      req_scale_steps <= v.scale_steps;
      start           <= 1'b1;
      do @(posedge clock); while (busy);
      tracker.note_vertex(v);
   endtask

   task automatic drain();
      start <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, longint val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= WORD_W'(val);
      @(posedge clock);
      tracker.set_reg(idx, word_type'(val));
      reg_writes++;
   endtask

   task automatic set_view(longint sx, longint sy, longint ox, longint oy);
      write_reg(CSR_VIEW_SCALE_X, sx);
      write_reg(CSR_VIEW_SCALE_Y, sy);
      write_reg(CSR_VIEW_OFFSET_X, ox);
      write_reg(CSR_VIEW_OFFSET_Y, oy);
      csr_write <= 1'b0;
   endtask

   initial begin
      tracker = new();
      reset           <= 1'b1;
      start           <= 1'b0;
      req_pos_x       <= '0;
      req_pos_y       <= '0;
      req_pos_z       <= '0;
      req_pos_w       <= '0;
      req_offset_x    <= '0;
      req_offset_y    <= '0;
      req_pivot_x     <= '0;
      req_pivot_y     <= '0;
      req_rot_steps   <= '0;
      req_scale_steps <= '0;
      csr_write       <= 1'b0;
      csr_index       <= '0;
      csr_data        <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed beats under the reset view settings
      add_directed(mk_vertex(0, 0, 0, 0, 0, 0, 0, 0, 0, 1));
      add_directed(mk_vertex(ONE_Q16, 0, 0, ONE_Q16, 0, 0, 0, 0, 9, 1));
      add_directed(mk_vertex(ONE_Q16, ONE_Q16, 5, ONE_Q16, 0, 0, 0, 0, 18, 0));
      add_directed(mk_vertex(3 * ONE_Q16, -ONE_Q16, 7, ONE_Q16, ONE_Q16, 0,
                             ONE_Q16, ONE_Q16, 27, 16));
      add_directed(mk_vertex(12345, -54321, 0, ONE_Q16, 0, 0, 100, -100, 36, -16));
      add_directed(mk_vertex(-99999, 77777, 0, ONE_Q16, 0, 0, 0, 0, -36, 1));
      add_directed(mk_vertex(ONE_Q16, 2 * ONE_Q16, 0, ONE_Q16, 0, 0, 0, 0, 127, 31));
      add_directed(mk_vertex(ONE_Q16, 2 * ONE_Q16, 0, ONE_Q16, 0, 0, 0, 0, -128, -32));
      add_directed(mk_vertex(ONE_Q16, 0, 0, ONE_Q16, 0, 0, 0, 0, 1, 17));
      add_directed(mk_vertex(ONE_Q16, 0, 0, ONE_Q16, 0, 0, 0, 0, -1, -17));
      // translate saturates high and low
      add_directed(mk_vertex(WORD_HI, WORD_HI, 0, ONE_Q16, WORD_HI, 1, 0, 0, 0, 1));
      add_directed(mk_vertex(WORD_LO, WORD_LO, 0, ONE_Q16, WORD_LO, -1, 0, 0, 0, 1));
      // rotation about a far pivot overflows
      add_directed(mk_vertex(WORD_HI, WORD_LO, 0, ONE_Q16, 0, 0, WORD_LO, WORD_HI,
                             18, 1));
      add_directed(mk_vertex(WORD_HI, WORD_LO, 0, ONE_Q16, 0, 0, WORD_LO, WORD_HI,
                             5, 1));
      // scaling away from a far pivot overflows
      add_directed(mk_vertex(4 * ONE_Q16, -4 * ONE_Q16, 0, ONE_Q16, 0, 0,
                             -WORD_HI, WORD_HI, 0, 16));
      add_directed(mk_vertex(0, 0, WORD_HI, WORD_LO, 0, 0, 0, 0, 0, 1));
      add_directed(mk_vertex(ONE_Q16, ONE_Q16, WORD_LO, WORD_HI, 0, 0, 0, 0, 5, 2));
      add_directed(mk_vertex(-ONE_Q16, 3 * ONE_Q16, -1, ONE_Q16, 0, 0, 0, 0, 72, -1));
      add_directed(mk_vertex(WORD_LO, WORD_LO, 1, -ONE_Q16, 0, 0, WORD_HI, WORD_HI,
                             4, 3));
      add_directed(mk_vertex(1, -1, 0, 1, -1, 1, 0, 0, 13, -5));
      add_directed(mk_vertex(-1, 1, 0, -1, 0, 0, -1, -1, -13, 5));
      foreach (directed_q[i]) begin
         idle_gap();
         send_vertex(directed_q[i]);
      end

      for (int ph = 1; ph <= PHASES; ph++) begin
         drain();
         case (ph)
            1: set_view(WORD_HI, WORD_LO, WORD_HI, WORD_LO);
            2: set_view(WORD_LO, WORD_HI, WORD_LO, WORD_HI);
            3: set_view(0, 0, rand_word(), rand_word());
            4: set_view(int'($urandom_range(0, 1 << 18)) - (1 << 17),
                        int'($urandom_range(0, 1 << 18)) - (1 << 17),
                        int'($urandom_range(0, 1 << 18)) - (1 << 17),
                        int'($urandom_range(0, 1 << 18)) - (1 << 17));
            5: set_view(word_type'($urandom), word_type'($urandom),
                        word_type'($urandom), word_type'($urandom));
            default: set_view(ONE_Q16, ONE_Q16, int'($urandom_range(0, 1 << 17)) - (1 << 16),
                              int'($urandom_range(0, 1 << 17)) - (1 << 16));
         endcase
         // one phase streams back to back with no random gaps
         quiet = (ph == 4);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // let the pipe run dry once per phase
            if (n == PHASE_ITEMS / 2) drain();
            idle_gap();
            send_vertex(rand_vertex());
         end
      end

      drain();
      repeat (4 * LATENCY) @(posedge clock);
      if (tracker.pending() != 0)
         tracker.report($sformatf("%0d vertices never came back", tracker.pending()));
      $display("summary: %0d vertices sent, %0d results checked, %0d mismatches",
               tracker.vertices, tracker.results, tracker.errors);
      $display("summary: %0d view settings, %0d register writes, %0d cycles",
               PHASES + 1, reg_writes, cycle_count);
      if (tracker.errors == 0) begin
         $display("tb_vertex_rotate_scale_view_transform OK");
      end else begin
         $display("tb_vertex_rotate_scale_view_transform NOT OK");
      end
      $finish;
   end

endmodule
